// ===== rtl/rvdec_pkg.sv =====
// shared types and codes for the risc-v main control and alu operation decoder
// no dependencies; imported by every module of the decoder

package rvdec_pkg;

    // major opcodes, bits 6..0 of the instruction
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_MULODD = 7'b0000001;
    localparam logic [6:0] OPC_FLOAD  = 7'b0000111;
    localparam logic [6:0] OPC_FSTORE = 7'b0100111;
    localparam logic [6:0] OPC_OPFP   = 7'b1010011;
    localparam logic [6:0] OPC_FMADD  = 7'b1000011;
    localparam logic [6:0] OPC_OPIMMW = 7'b0011011;
    localparam logic [6:0] OPC_OPW    = 7'b0111011;

    // main control flags
    typedef struct packed {
        logic alu_src;
        logic mem_to_reg;
        logic reg_write;
        logic mem_read;
        logic mem_write;
        logic is_branch;
        logic alu_active;
    } t_ctrl;

    typedef logic [6:0] t_alu_op;

    // alu operation codes
    localparam t_alu_op OP_NONE      = 7'd0;
    localparam t_alu_op OP_ADD       = 7'd1;
    localparam t_alu_op OP_SUB       = 7'd2;
    localparam t_alu_op OP_MUL       = 7'd3;
    localparam t_alu_op OP_SLL       = 7'd4;
    localparam t_alu_op OP_MULH      = 7'd5;
    localparam t_alu_op OP_SLT       = 7'd6;
    localparam t_alu_op OP_MULHSU    = 7'd7;
    localparam t_alu_op OP_SLTU      = 7'd8;
    localparam t_alu_op OP_MULHU     = 7'd9;
    localparam t_alu_op OP_XOR       = 7'd10;
    localparam t_alu_op OP_DIV       = 7'd11;
    localparam t_alu_op OP_SRL       = 7'd12;
    localparam t_alu_op OP_SRA       = 7'd13;
    localparam t_alu_op OP_DIVU      = 7'd14;
    localparam t_alu_op OP_OR        = 7'd15;
    localparam t_alu_op OP_REM       = 7'd16;
    localparam t_alu_op OP_AND       = 7'd17;
    localparam t_alu_op OP_REMU      = 7'd18;
    localparam t_alu_op OP_ADDW      = 7'd19;
    localparam t_alu_op OP_SLLW      = 7'd20;
    localparam t_alu_op OP_SRLW      = 7'd21;
    localparam t_alu_op OP_SRAW      = 7'd22;
    localparam t_alu_op OP_SUBW      = 7'd23;
    localparam t_alu_op OP_MULW      = 7'd24;
    localparam t_alu_op OP_DIVW      = 7'd25;
    localparam t_alu_op OP_DIVUW     = 7'd26;
    localparam t_alu_op OP_REMW      = 7'd27;
    localparam t_alu_op OP_REMUW     = 7'd28;
    localparam t_alu_op OP_FMADD_S   = 7'd29;
    localparam t_alu_op OP_FADD_S    = 7'd30;
    localparam t_alu_op OP_FADD_D    = 7'd31;
    localparam t_alu_op OP_FSUB_S    = 7'd32;
    localparam t_alu_op OP_FSUB_D    = 7'd33;
    localparam t_alu_op OP_FMUL_S    = 7'd34;
    localparam t_alu_op OP_FMUL_D    = 7'd35;
    localparam t_alu_op OP_FDIV_S    = 7'd36;
    localparam t_alu_op OP_FDIV_D    = 7'd37;
    localparam t_alu_op OP_FSQRT_S   = 7'd38;
    localparam t_alu_op OP_FSQRT_D   = 7'd39;
    localparam t_alu_op OP_FCVT_W_S  = 7'd40; // first of W, WU, L, LU
    localparam t_alu_op OP_FCVT_W_D  = 7'd44;
    localparam t_alu_op OP_FCVT_S_W  = 7'd48;
    localparam t_alu_op OP_FCVT_D_W  = 7'd52;
    localparam t_alu_op OP_FSGNJ_S   = 7'd56;
    localparam t_alu_op OP_FSGNJN_S  = 7'd57;
    localparam t_alu_op OP_FSGNJX_S  = 7'd58;
    localparam t_alu_op OP_FSGNJ_D   = 7'd59;
    localparam t_alu_op OP_FSGNJN_D  = 7'd60;
    localparam t_alu_op OP_FSGNJX_D  = 7'd61;
    localparam t_alu_op OP_FMIN_S    = 7'd62;
    localparam t_alu_op OP_FMAX_S    = 7'd63;
    localparam t_alu_op OP_FMIN_D    = 7'd64;
    localparam t_alu_op OP_FMAX_D    = 7'd65;
    localparam t_alu_op OP_FEQ_S     = 7'd66;
    localparam t_alu_op OP_FLT_S     = 7'd67;
    localparam t_alu_op OP_FLE_S     = 7'd68;
    localparam t_alu_op OP_FEQ_D     = 7'd69;
    localparam t_alu_op OP_FLT_D     = 7'd70;
    localparam t_alu_op OP_FLE_D     = 7'd71;
    localparam t_alu_op OP_FMV_W_X   = 7'd72;
    localparam t_alu_op OP_FMV_D_X   = 7'd73;
    localparam t_alu_op OP_FMV_X_W   = 7'd74;
    localparam t_alu_op OP_FCLASS_S  = 7'd75;
    localparam t_alu_op OP_FMV_X_D   = 7'd76;
    localparam t_alu_op OP_FCLASS_D  = 7'd77;

endpackage

// ===== rtl/rvdec_ctrl_dec.sv =====
// main control flag decode from the major opcode
// depends on rvdec_pkg

module rvdec_ctrl_dec (
    input  logic [31:0]         i_instr,
    output rvdec_pkg::t_ctrl    o_ctrl
);
    import rvdec_pkg::*;

    always_comb begin
        o_ctrl = '0;
        unique case (i_instr[6:0])
            OPC_OP, OPC_MULODD, OPC_OPFP: begin
                o_ctrl.reg_write  = 1'b1;
                o_ctrl.alu_active = 1'b1;
            end
            OPC_LOAD, OPC_FLOAD: begin
                o_ctrl.alu_src    = 1'b1;
                o_ctrl.mem_to_reg = 1'b1;
                o_ctrl.reg_write  = 1'b1;
                o_ctrl.mem_read   = 1'b1;
            end
            OPC_STORE, OPC_FSTORE: begin
                o_ctrl.alu_src    = 1'b1;
                o_ctrl.alu_active = 1'b1;
                o_ctrl.mem_write  = 1'b1;
            end
            OPC_BRANCH: begin
                o_ctrl.alu_active = 1'b1;
                o_ctrl.is_branch  = 1'b1;
            end
            OPC_OPIMM, OPC_LUI, OPC_AUIPC: begin
                o_ctrl.alu_src    = 1'b1;
                o_ctrl.reg_write  = 1'b1;
                o_ctrl.alu_active = 1'b1;
            end
            OPC_JAL: begin
                o_ctrl.reg_write  = 1'b1;
                o_ctrl.is_branch  = 1'b1;
            end
            OPC_JALR: begin
                o_ctrl.alu_src    = 1'b1;
                o_ctrl.reg_write  = 1'b1;
                o_ctrl.is_branch  = 1'b1;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

// ===== rtl/rvdec_alu_dec.sv =====
// alu operation code decode from opcode, funct3, funct7 and funct5
// depends on rvdec_pkg

module rvdec_alu_dec (
    input  logic [31:0]         i_instr,
    output rvdec_pkg::t_alu_op  o_alu_op
);
    import rvdec_pkg::*;

    // integer funct7 values
    localparam logic [6:0] F7_ZERO = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;

    // op-fp funct7 values
    localparam logic [6:0] F7_FADD_S   = 7'h00;
    localparam logic [6:0] F7_FADD_D   = 7'h01;
    localparam logic [6:0] F7_FSUB_S   = 7'h04;
    localparam logic [6:0] F7_FSUB_D   = 7'h05;
    localparam logic [6:0] F7_FMUL_S   = 7'h08;
    localparam logic [6:0] F7_FMUL_D   = 7'h09;
    localparam logic [6:0] F7_FDIV_S   = 7'h0C;
    localparam logic [6:0] F7_FDIV_D   = 7'h0D;
    localparam logic [6:0] F7_FSQRT_S  = 7'h2C;
    localparam logic [6:0] F7_FSQRT_D  = 7'h2D;
    localparam logic [6:0] F7_FCVT_I_S = 7'h60;
    localparam logic [6:0] F7_FCVT_I_D = 7'h61;
    localparam logic [6:0] F7_FCVT_S_I = 7'h68;
    localparam logic [6:0] F7_FCVT_D_I = 7'h69;
    localparam logic [6:0] F7_FSGNJ_S  = 7'h10;
    localparam logic [6:0] F7_FSGNJ_D  = 7'h11;
    localparam logic [6:0] F7_FMINMX_S = 7'h14;
    localparam logic [6:0] F7_FMINMX_D = 7'h15;
    localparam logic [6:0] F7_FCMP_S   = 7'h50;
    localparam logic [6:0] F7_FCMP_D   = 7'h51;
    localparam logic [6:0] F7_FMV_W_X  = 7'h78;
    localparam logic [6:0] F7_FMV_D_X  = 7'h79;
    localparam logic [6:0] F7_FMV_X_W  = 7'h70;
    localparam logic [6:0] F7_FMV_X_D  = 7'h71;

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] f5;
    t_alu_op    fcvt_ofs;
    t_alu_op    f3_ofs;

    assign opc      = i_instr[6:0];
    assign f3       = i_instr[14:12];
    assign f7       = i_instr[31:25];
    assign f5       = i_instr[24:20];
    assign fcvt_ofs = {5'b0, f5[1:0]};
    assign f3_ofs   = {4'b0, f3};

    always_comb begin
        o_alu_op = OP_NONE;
        unique case (opc)
            OPC_OP: begin
                if (f7 == F7_ZERO) begin
                    unique case (f3)
                        3'd0:    o_alu_op = OP_ADD;
                        3'd1:    o_alu_op = OP_SLL;
                        3'd2:    o_alu_op = OP_SLT;
                        3'd3:    o_alu_op = OP_SLTU;
                        3'd4:    o_alu_op = OP_XOR;
                        3'd5:    o_alu_op = OP_SRL;
                        3'd6:    o_alu_op = OP_OR;
                        default: o_alu_op = OP_AND;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == 3'd0)      o_alu_op = OP_SUB;
                    else if (f3 == 3'd5) o_alu_op = OP_SRA;
                end else if (f7 == F7_MUL) begin
                    unique case (f3)
                        3'd0:    o_alu_op = OP_MUL;
                        3'd1:    o_alu_op = OP_MULH;
                        3'd2:    o_alu_op = OP_MULHSU;
                        3'd3:    o_alu_op = OP_MULHU;
                        3'd4:    o_alu_op = OP_DIV;
                        3'd5:    o_alu_op = OP_DIVU;
                        3'd6:    o_alu_op = OP_REM;
                        default: o_alu_op = OP_REMU;
                    endcase
                end
            end
            OPC_OPIMM: begin
                unique case (f3)
                    3'd0: o_alu_op = OP_ADD;
                    3'd1: o_alu_op = OP_SLL;
                    3'd2: o_alu_op = OP_SLT;
                    3'd3: o_alu_op = OP_SLTU;
                    3'd4: o_alu_op = OP_XOR;
                    3'd5: begin
                        // full funct7 compare, so shamt bit 5 gives none
                        if (f7 == F7_ZERO)     o_alu_op = OP_SRL;
                        else if (f7 == F7_ALT) o_alu_op = OP_SRA;
                    end
                    3'd6:    o_alu_op = OP_OR;
                    default: o_alu_op = OP_AND;
                endcase
            end
            OPC_BRANCH: begin
                unique case (f3)
                    3'd0, 3'd1: o_alu_op = OP_SUB;
                    3'd4, 3'd5: o_alu_op = OP_SLT;
                    3'd6, 3'd7: o_alu_op = OP_SLTU;
                    default:    o_alu_op = OP_NONE;
                endcase
            end
            OPC_LOAD, OPC_STORE, OPC_JALR, OPC_JAL, OPC_LUI, OPC_AUIPC: begin
                o_alu_op = OP_ADD;
            end
            OPC_OPIMMW: begin
                if (f3 == 3'd0)      o_alu_op = OP_ADDW;
                else if (f3 == 3'd1) o_alu_op = OP_SLLW;
                else if (f3 == 3'd5) begin
                    if (f7 == F7_ZERO)     o_alu_op = OP_SRLW;
                    else if (f7 == F7_ALT) o_alu_op = OP_SRAW;
                end
            end
            OPC_OPW: begin
                if (f3 == 3'd0) begin
                    if (f7 == F7_ZERO)     o_alu_op = OP_ADDW;
                    else if (f7 == F7_ALT) o_alu_op = OP_SUBW;
                    else if (f7 == F7_MUL) o_alu_op = OP_MULW;
                end else if (f3 == 3'd1) begin
                    // funct7 is not checked here
                    o_alu_op = OP_SLLW;
                end else if (f3 == 3'd5) begin
                    if (f7 == F7_ZERO)     o_alu_op = OP_SRLW;
                    else if (f7 == F7_ALT) o_alu_op = OP_SRAW;
                    else if (f7 == F7_MUL) o_alu_op = OP_DIVUW;
                end else if (f7 == F7_MUL) begin
                    if (f3 == 3'd4)      o_alu_op = OP_DIVW;
                    else if (f3 == 3'd6) o_alu_op = OP_REMW;
                    else if (f3 == 3'd7) o_alu_op = OP_REMUW;
                end
            end
            OPC_FMADD: begin
                o_alu_op = OP_FMADD_S;
            end
            OPC_OPFP: begin
                unique case (f7)
                    F7_FADD_S:  o_alu_op = OP_FADD_S;
                    F7_FADD_D:  o_alu_op = OP_FADD_D;
                    F7_FSUB_S:  o_alu_op = OP_FSUB_S;
                    F7_FSUB_D:  o_alu_op = OP_FSUB_D;
                    F7_FMUL_S:  o_alu_op = OP_FMUL_S;
                    F7_FMUL_D:  o_alu_op = OP_FMUL_D;
                    F7_FDIV_S:  o_alu_op = OP_FDIV_S;
                    F7_FDIV_D:  o_alu_op = OP_FDIV_D;
                    F7_FSQRT_S: o_alu_op = OP_FSQRT_S;
                    F7_FSQRT_D: o_alu_op = OP_FSQRT_D;
                    F7_FCVT_I_S: if (f5[4:2] == 3'd0) o_alu_op = OP_FCVT_W_S + fcvt_ofs;
                    F7_FCVT_I_D: if (f5[4:2] == 3'd0) o_alu_op = OP_FCVT_W_D + fcvt_ofs;
                    F7_FCVT_S_I: if (f5[4:2] == 3'd0) o_alu_op = OP_FCVT_S_W + fcvt_ofs;
                    F7_FCVT_D_I: if (f5[4:2] == 3'd0) o_alu_op = OP_FCVT_D_W + fcvt_ofs;
                    F7_FSGNJ_S:  if (f3 < 3'd3) o_alu_op = OP_FSGNJ_S + f3_ofs;
                    F7_FSGNJ_D:  if (f3 < 3'd3) o_alu_op = OP_FSGNJ_D + f3_ofs;
                    F7_FMINMX_S: if (f3 < 3'd2) o_alu_op = OP_FMIN_S + f3_ofs;
                    F7_FMINMX_D: if (f3 < 3'd2) o_alu_op = OP_FMIN_D + f3_ofs;
                    // compare codes run le, lt, eq as funct3 counts up
                    F7_FCMP_S:   if (f3 < 3'd3) o_alu_op = OP_FLE_S - f3_ofs;
                    F7_FCMP_D:   if (f3 < 3'd3) o_alu_op = OP_FLE_D - f3_ofs;
                    F7_FMV_W_X:  o_alu_op = OP_FMV_W_X;
                    F7_FMV_D_X:  o_alu_op = OP_FMV_D_X;
                    F7_FMV_X_W:  if (f3 < 3'd2) o_alu_op = OP_FMV_X_W + f3_ofs;
                    F7_FMV_X_D:  if (f3 < 3'd2) o_alu_op = OP_FMV_X_D + f3_ofs;
                    default:     o_alu_op = OP_NONE;
                endcase
            end
            OPC_FLOAD, OPC_FSTORE: begin
                if (f3 == 3'd2 || f3 == 3'd3) o_alu_op = OP_ADD;
            end
            default: begin
                o_alu_op = OP_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/riscv_main_and_alu_decoder_core.sv =====
// Main control and alu operation decoder for an rv64 i/m/f/d core. Each request
// carries one 32-bit instruction word and yields one result: seven control flags
// decoded from the major opcode (alu source, memory to register, register write,
// memory read, memory write, branch, alu active) and a 7-bit alu operation code
// decoded from opcode, funct3, funct7 and funct5, with 0 meaning no operation for
// any encoding that is not recognized. The block is a two-stage pipeline: the
// instruction is captured in an input register, decoded by short combinational
// logic, and the flags and code land in a result register, from which they drive
// the outputs. One request is accepted every cycle as long as the output side
// keeps taking results; the result register and input register each hold one
// request, so the input side stalls only when both are full and the output is
// not ready. The decoder holds no architectural state and has no configuration.
// depends on rvdec_pkg, rvdec_ctrl_dec and rvdec_alu_dec

module riscv_main_and_alu_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request side
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instruction_word,

    // result side
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_alu_src,
    output logic        o_mem_to_reg,
    output logic        o_reg_write,
    output logic        o_mem_read,
    output logic        o_mem_write,
    output logic        o_is_branch,
    output logic        o_alu_active,
    output logic [6:0]  o_alu_operation
);
    import rvdec_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [31:0] r_instr;

    // result stage
    logic        r_out_valid;
    t_ctrl       r_ctrl;
    t_alu_op     r_alu_op;

    // decoded next values for the result stage
    t_ctrl       n_ctrl;
    t_alu_op     n_alu_op;

    logic        out_stage_ready;

    // result stage can load when empty or when its request is taken this cycle
    assign out_stage_ready = !r_out_valid || i_out_ready;
    // input stage can load when empty or when it moves forward this cycle
    assign o_in_ready      = !r_in_valid || out_stage_ready;

    rvdec_ctrl_dec u_ctrl_dec (
        .i_instr (r_instr),
        .o_ctrl  (n_ctrl)
    );

    rvdec_alu_dec u_alu_dec (
        .i_instr  (r_instr),
        .o_alu_op (n_alu_op)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_stage_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_instr <= i_instruction_word;
        end
        if (r_in_valid && out_stage_ready) begin
            r_ctrl   <= n_ctrl;
            r_alu_op <= n_alu_op;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_alu_src       = r_ctrl.alu_src;
    assign o_mem_to_reg    = r_ctrl.mem_to_reg;
    assign o_reg_write     = r_ctrl.reg_write;
    assign o_mem_read      = r_ctrl.mem_read;
    assign o_mem_write     = r_ctrl.mem_write;
    assign o_is_branch     = r_ctrl.is_branch;
    assign o_alu_active    = r_ctrl.alu_active;
    assign o_alu_operation = r_alu_op;

    // an empty result stage never stalls the input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result stage");

    // a decoded request moving forward shows up on the output next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_stage_ready) |=> o_out_valid)
        else $error("decoded request lost between stages");

    // a loaded request is not dropped while the result stage is blocked
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_stage_ready) |=> (r_in_valid && $stable(r_instr)))
        else $error("input stage changed while blocked");

    // loads and stores are exclusive, and memory to register only with a read
    a_mem_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_mem_read && o_mem_write) && (!o_mem_to_reg || o_mem_read)))
        else $error("inconsistent memory control flags");

    // stores never write the register file
    a_store_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mem_write) |-> !o_reg_write)
        else $error("store with register write");

endmodule

// ===== tb/riscv_main_and_alu_decoder_core_tb.sv =====
// testbench for the rv64 main control and alu operation decoder core
// drives instruction words through valid/ready, predicts flags and alu codes per request
// depends on rvdec_pkg and riscv_main_and_alu_decoder_core
`timescale 1ns / 100ps

module riscv_main_and_alu_decoder_core_tb;

    import rvdec_pkg::*;

    // funct7 values that steer the integer decode
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    // funct7 values of the op-fp group
    localparam logic [6:0] F7_FADD_S   = 7'h00;
    localparam logic [6:0] F7_FADD_D   = 7'h01;
    localparam logic [6:0] F7_FSUB_S   = 7'h04;
    localparam logic [6:0] F7_FSUB_D   = 7'h05;
    localparam logic [6:0] F7_FMUL_S   = 7'h08;
    localparam logic [6:0] F7_FMUL_D   = 7'h09;
    localparam logic [6:0] F7_FDIV_S   = 7'h0C;
    localparam logic [6:0] F7_FDIV_D   = 7'h0D;
    localparam logic [6:0] F7_FSQRT_S  = 7'h2C;
    localparam logic [6:0] F7_FSQRT_D  = 7'h2D;
    localparam logic [6:0] F7_FCVT_XS  = 7'h60;
    localparam logic [6:0] F7_FCVT_XD  = 7'h61;
    localparam logic [6:0] F7_FCVT_SX  = 7'h68;
    localparam logic [6:0] F7_FCVT_DX  = 7'h69;
    localparam logic [6:0] F7_FSGNJ_S  = 7'h10;
    localparam logic [6:0] F7_FSGNJ_D  = 7'h11;
    localparam logic [6:0] F7_FMINMAX_S = 7'h14;
    localparam logic [6:0] F7_FMINMAX_D = 7'h15;
    localparam logic [6:0] F7_FCMP_S   = 7'h50;
    localparam logic [6:0] F7_FCMP_D   = 7'h51;
    localparam logic [6:0] F7_FMV_W_X  = 7'h78;
    localparam logic [6:0] F7_FMV_D_X  = 7'h79;
    localparam logic [6:0] F7_FMV_X_W  = 7'h70;
    localparam logic [6:0] F7_FMV_X_D  = 7'h71;

    // a fused opcode other than fmadd, never decoded
    localparam logic [6:0] OPC_FMSUB = 7'b1000111;

    localparam int CLK_HALF   = 2;
    localparam int N_RANDOM   = 450;
    localparam int DRAIN_MID  = 250;
    localparam int CALM_FROM  = 300;
    localparam int CALM_TO    = 400;
    localparam int IDLE_PCT   = 7;
    localparam int TAIL_CYC   = 10;
    localparam int CYCLE_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    // one expected decode, kept with its instruction for reporting
    typedef struct packed {
        logic [31:0] word;
        t_ctrl       ctrl;
        t_alu_op     op;
    } t_decode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_instruction_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_alu_src;
    logic        o_mem_to_reg;
    logic        o_reg_write;
    logic        o_mem_read;
    logic        o_mem_write;
    logic        o_is_branch;
    logic        o_alu_active;
    logic [6:0]  o_alu_operation;

    logic [31:0] instr_q[$];     // instructions not yet offered
    t_decode     decode_q[$];    // accepted requests awaiting their result
    int          issued = 0;
    int          n_directed = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    logic        calm;

    riscv_main_and_alu_decoder_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_instruction_word (i_instruction_word),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_alu_src          (o_alu_src),
        .o_mem_to_reg       (o_mem_to_reg),
        .o_reg_write        (o_reg_write),
        .o_mem_read         (o_mem_read),
        .o_mem_write        (o_mem_write),
        .o_is_branch        (o_is_branch),
        .o_alu_active       (o_alu_active),
        .o_alu_operation    (o_alu_operation)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // predicted control flags and alu code for one instruction word
    function automatic t_decode decode_expected(logic [31:0] w);
        t_decode     d;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  f5;
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];
        f5  = w[24:20];
        d.word = w;
        d.ctrl = '0;
        d.op   = OP_NONE;

        // main control flags come from the opcode alone
        case (opc)
            OPC_OP, OPC_MULODD, OPC_OPFP: begin
                d.ctrl.reg_write  = 1'b1;
                d.ctrl.alu_active = 1'b1;
            end
            OPC_LOAD, OPC_FLOAD: begin
                d.ctrl.alu_src    = 1'b1;
                d.ctrl.mem_to_reg = 1'b1;
                d.ctrl.reg_write  = 1'b1;
                d.ctrl.mem_read   = 1'b1;
            end
            OPC_STORE, OPC_FSTORE: begin
                d.ctrl.alu_src    = 1'b1;
                d.ctrl.alu_active = 1'b1;
                d.ctrl.mem_write  = 1'b1;
            end
            OPC_BRANCH: begin
                d.ctrl.alu_active = 1'b1;
                d.ctrl.is_branch  = 1'b1;
            end
            OPC_OPIMM, OPC_LUI, OPC_AUIPC: begin
                d.ctrl.alu_src    = 1'b1;
                d.ctrl.reg_write  = 1'b1;
                d.ctrl.alu_active = 1'b1;
            end
            OPC_JAL: begin
                d.ctrl.reg_write  = 1'b1;
                d.ctrl.is_branch  = 1'b1;
            end
            OPC_JALR: begin
                d.ctrl.alu_src    = 1'b1;
                d.ctrl.reg_write  = 1'b1;
                d.ctrl.is_branch  = 1'b1;
            end
            default: ;
        endcase

        // alu operation code
        case (opc)
            OPC_OP: begin
                if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0: d.op = OP_ADD;
                        3'd1: d.op = OP_SLL;
                        3'd2: d.op = OP_SLT;
                        3'd3: d.op = OP_SLTU;
                        3'd4: d.op = OP_XOR;
                        3'd5: d.op = OP_SRL;
                        3'd6: d.op = OP_OR;
                        default: d.op = OP_AND;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == 3'd0) d.op = OP_SUB;
                    else if (f3 == 3'd5) d.op = OP_SRA;
                end else if (f7 == F7_MULDIV) begin
                    case (f3)
                        3'd0: d.op = OP_MUL;
                        3'd1: d.op = OP_MULH;
                        3'd2: d.op = OP_MULHSU;
                        3'd3: d.op = OP_MULHU;
                        3'd4: d.op = OP_DIV;
                        3'd5: d.op = OP_DIVU;
                        3'd6: d.op = OP_REM;
                        default: d.op = OP_REMU;
                    endcase
                end
            end
            OPC_OPIMM: begin
                case (f3)
                    3'd0: d.op = OP_ADD;
                    3'd1: d.op = OP_SLL;
                    3'd2: d.op = OP_SLT;
                    3'd3: d.op = OP_SLTU;
                    3'd4: d.op = OP_XOR;
                    // full funct7 compared, so shamt bit 5 set gives none
                    3'd5: begin
                        if (f7 == F7_BASE) d.op = OP_SRL;
                        else if (f7 == F7_ALT) d.op = OP_SRA;
                    end
                    3'd6: d.op = OP_OR;
                    default: d.op = OP_AND;
                endcase
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0, 3'd1: d.op = OP_SUB;
                    3'd4, 3'd5: d.op = OP_SLT;
                    3'd6, 3'd7: d.op = OP_SLTU;
                    default: d.op = OP_NONE;
                endcase
            end
            OPC_LOAD, OPC_STORE, OPC_JALR, OPC_JAL, OPC_LUI, OPC_AUIPC:
                d.op = OP_ADD;
            OPC_OPIMMW: begin
                if (f3 == 3'd0) d.op = OP_ADDW;
                else if (f3 == 3'd1) d.op = OP_SLLW;
                else if (f3 == 3'd5) begin
                    if (f7 == F7_BASE) d.op = OP_SRLW;
                    else if (f7 == F7_ALT) d.op = OP_SRAW;
                end
            end
            OPC_OPW: begin
                if (f3 == 3'd0) begin
                    if (f7 == F7_BASE) d.op = OP_ADDW;
                    else if (f7 == F7_ALT) d.op = OP_SUBW;
                    else if (f7 == F7_MULDIV) d.op = OP_MULW;
                end else if (f3 == 3'd1) begin
                    // sllw ignores funct7
                    d.op = OP_SLLW;
                end else if (f3 == 3'd5) begin
                    if (f7 == F7_BASE) d.op = OP_SRLW;
                    else if (f7 == F7_ALT) d.op = OP_SRAW;
                    else if (f7 == F7_MULDIV) d.op = OP_DIVUW;
                end else if (f7 == F7_MULDIV) begin
                    if (f3 == 3'd4) d.op = OP_DIVW;
                    else if (f3 == 3'd6) d.op = OP_REMW;
                    else if (f3 == 3'd7) d.op = OP_REMUW;
                end
            end
            OPC_FMADD:
                d.op = OP_FMADD_S;
            OPC_OPFP: begin
                case (f7)
                    F7_FADD_S:  d.op = OP_FADD_S;
                    F7_FADD_D:  d.op = OP_FADD_D;
                    F7_FSUB_S:  d.op = OP_FSUB_S;
                    F7_FSUB_D:  d.op = OP_FSUB_D;
                    F7_FMUL_S:  d.op = OP_FMUL_S;
                    F7_FMUL_D:  d.op = OP_FMUL_D;
                    F7_FDIV_S:  d.op = OP_FDIV_S;
                    F7_FDIV_D:  d.op = OP_FDIV_D;
                    F7_FSQRT_S: d.op = OP_FSQRT_S;
                    F7_FSQRT_D: d.op = OP_FSQRT_D;
                    // conversions index by funct5, only 0..3 valid
                    F7_FCVT_XS: if (f5 < 5'd4) d.op = OP_FCVT_W_S + t_alu_op'(f5);
                    F7_FCVT_XD: if (f5 < 5'd4) d.op = OP_FCVT_W_D + t_alu_op'(f5);
                    F7_FCVT_SX: if (f5 < 5'd4) d.op = OP_FCVT_S_W + t_alu_op'(f5);
                    F7_FCVT_DX: if (f5 < 5'd4) d.op = OP_FCVT_D_W + t_alu_op'(f5);
                    F7_FSGNJ_S: if (f3 < 3'd3) d.op = OP_FSGNJ_S + t_alu_op'(f3);
                    F7_FSGNJ_D: if (f3 < 3'd3) d.op = OP_FSGNJ_D + t_alu_op'(f3);
                    F7_FMINMAX_S: if (f3 < 3'd2) d.op = OP_FMIN_S + t_alu_op'(f3);
                    F7_FMINMAX_D: if (f3 < 3'd2) d.op = OP_FMIN_D + t_alu_op'(f3);
                    // compares: funct3 0 le, 1 lt, 2 eq
                    F7_FCMP_S:  if (f3 < 3'd3) d.op = OP_FLE_S - t_alu_op'(f3);
                    F7_FCMP_D:  if (f3 < 3'd3) d.op = OP_FLE_D - t_alu_op'(f3);
                    // moves into float registers ignore funct3
                    F7_FMV_W_X: d.op = OP_FMV_W_X;
                    F7_FMV_D_X: d.op = OP_FMV_D_X;
                    F7_FMV_X_W: if (f3 < 3'd2) d.op = OP_FMV_X_W + t_alu_op'(f3);
                    F7_FMV_X_D: if (f3 < 3'd2) d.op = OP_FMV_X_D + t_alu_op'(f3);
                    default: d.op = OP_NONE;
                endcase
            end
            OPC_FLOAD, OPC_FSTORE:
                if (f3 == 3'd2 || f3 == 3'd3) d.op = OP_ADD;
            default: d.op = OP_NONE;
        endcase
        return d;
    endfunction

    // instruction word from its fields, register numbers random
    function automatic logic [31:0] make_instr(logic [6:0] f7, logic [4:0] f5,
                                               logic [2:0] f3, logic [6:0] opc);
        logic [4:0] rs1;
        logic [4:0] rd;
        rs1 = 5'($urandom);
        rd  = 5'($urandom);
        return {f7, f5, rs1, f3, rd, opc};
    endfunction

    function automatic logic [6:0] pick_opcode();
        case ($urandom_range(0, 17))
            0:  return OPC_OP;
            1:  return OPC_LOAD;
            2:  return OPC_STORE;
            3:  return OPC_BRANCH;
            4:  return OPC_OPIMM;
            5:  return OPC_LUI;
            6:  return OPC_AUIPC;
            7:  return OPC_JAL;
            8:  return OPC_JALR;
            9:  return OPC_MULODD;
            10: return OPC_FLOAD;
            11: return OPC_FSTORE;
            12: return OPC_FMADD;
            13: return OPC_OPIMMW;
            14: return OPC_OPW;
            15: return OPC_FMSUB;
            default: return OPC_OPFP;
        endcase
    endfunction

    function automatic logic [6:0] pick_funct7();
        case ($urandom_range(0, 26))
            0:  return F7_ALT;
            1:  return F7_MULDIV;
            2:  return F7_FSUB_S;
            3:  return F7_FSUB_D;
            4:  return F7_FMUL_S;
            5:  return F7_FMUL_D;
            6:  return F7_FDIV_S;
            7:  return F7_FDIV_D;
            8:  return F7_FSQRT_S;
            9:  return F7_FSQRT_D;
            10: return F7_FCVT_XS;
            11: return F7_FCVT_XD;
            12: return F7_FCVT_SX;
            13: return F7_FCVT_DX;
            14: return F7_FSGNJ_S;
            15: return F7_FSGNJ_D;
            16: return F7_FMINMAX_S;
            17: return F7_FMINMAX_D;
            18: return F7_FCMP_S;
            19: return F7_FCMP_D;
            20: return F7_FMV_W_X;
            21: return F7_FMV_D_X;
            22: return F7_FMV_X_W;
            23: return F7_FMV_X_D;
            24: return 7'($urandom);
            default: return F7_BASE;
        endcase
    endfunction

    // the quiet stretch: neither side idles
    assign calm = (issued >= CALM_FROM) && (issued < CALM_TO);

    // request driver, fed from instr_q
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_q.push_back(decode_expected(i_instruction_word));
            end
            // a new request may go out once the current one is taken
            if (!i_in_valid || o_in_ready) begin
                if (instr_q.size() != 0
                        && !((issued == n_directed || issued == DRAIN_MID)
                             && decode_q.size() != 0)
                        && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_in_valid         <= 1'b1;
                    i_instruction_word <= instr_q.pop_front();
                    issued             <= issued + 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result monitor: compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        t_decode want;
        t_ctrl   got_ctrl;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_ctrl = '{o_alu_src, o_mem_to_reg, o_reg_write, o_mem_read,
                         o_mem_write, o_is_branch, o_alu_active};
            if (decode_q.size() == 0) begin
                err_cnt <= err_cnt + 1;
                if (err_cnt < MAX_REPORTS)
                    $display("unexpected result: flags %b op %0d", got_ctrl, o_alu_operation);
            end else begin
                want = decode_q.pop_front();
                if (got_ctrl.alu_src !== want.ctrl.alu_src
                        || got_ctrl.mem_to_reg !== want.ctrl.mem_to_reg
                        || got_ctrl.reg_write !== want.ctrl.reg_write
                        || got_ctrl.mem_read !== want.ctrl.mem_read
                        || got_ctrl.mem_write !== want.ctrl.mem_write
                        || got_ctrl.is_branch !== want.ctrl.is_branch
                        || got_ctrl.alu_active !== want.ctrl.alu_active
                        || o_alu_operation !== want.op) begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < MAX_REPORTS)
                        $display("mismatch instr %h: expected flags %b op %0d, %s %b op %0d",
                                 want.word, want.ctrl, want.op, "got flags",
                                 got_ctrl, o_alu_operation);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("riscv_main_and_alu_decoder_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [31:0] w;
        logic [4:0]  f5;

        // directed requests: field extremes, most opcode groups and the odd corners
        instr_q.push_back(32'h0000_0000);
        instr_q.push_back(32'hFFFF_FFFF);
        instr_q.push_back(make_instr(F7_BASE, 5'd3, 3'd0, OPC_OP));
        instr_q.push_back(make_instr(F7_ALT, 5'd3, 3'd0, OPC_OP));
        instr_q.push_back(make_instr(F7_MULDIV, 5'd3, 3'd7, OPC_OP));
        instr_q.push_back(make_instr(F7_ALT, 5'd4, 3'd1, OPC_OP));
        // shift immediate with shamt of 32 or more
        instr_q.push_back(make_instr(F7_MULDIV, 5'd1, 3'd5, OPC_OPIMM));
        instr_q.push_back(make_instr(F7_ALT, 5'd1, 3'd5, OPC_OPIMM));
        // odd multiply opcode: flags set, op none
        instr_q.push_back(make_instr(F7_MULDIV, 5'd2, 3'd0, OPC_MULODD));
        instr_q.push_back(make_instr(7'h7F, 5'h1F, 3'd7, OPC_FMADD));
        instr_q.push_back(make_instr(F7_BASE, 5'd0, 3'd0, OPC_FMSUB));
        // conversion with funct5 past the table, sign inject with bad funct3
        instr_q.push_back(make_instr(F7_FCVT_DX, 5'd4, 3'd0, OPC_OPFP));
        instr_q.push_back(make_instr(F7_FCVT_XS, 5'd3, 3'd1, OPC_OPFP));
        instr_q.push_back(make_instr(F7_FSGNJ_S, 5'd0, 3'd3, OPC_OPFP));
        instr_q.push_back(make_instr(F7_FCMP_D, 5'd0, 3'd2, OPC_OPFP));
        // float moves in ignore funct3
        instr_q.push_back(make_instr(F7_FMV_W_X, 5'd0, 3'd7, OPC_OPFP));
        instr_q.push_back(make_instr(F7_FMV_X_D, 5'd0, 3'd1, OPC_OPFP));
        instr_q.push_back(make_instr(F7_BASE, 5'd0, 3'd2, OPC_FLOAD));
        instr_q.push_back(make_instr(F7_BASE, 5'd0, 3'd0, OPC_FSTORE));
        instr_q.push_back(make_instr(F7_MULDIV, 5'd0, 3'd5, OPC_OPW));
        instr_q.push_back(make_instr(F7_ALT, 5'd0, 3'd5, OPC_OPIMMW));
        instr_q.push_back(make_instr(F7_ALT, 5'd0, 3'd2, OPC_BRANCH));
        instr_q.push_back(make_instr(7'h55, 5'd9, 3'd3, OPC_LUI));
        instr_q.push_back(make_instr(7'h2A, 5'd22, 3'd4, OPC_JAL));
        instr_q.push_back(make_instr(F7_BASE, 5'd0, 3'd0, OPC_JALR));
        n_directed = instr_q.size();

        // random part: mostly known groups with random fields, some raw words
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                w = $urandom;
            end else begin
                f5 = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 5)) : 5'($urandom);
                w = make_instr(($urandom_range(0, 1) != 0) ? pick_funct7() : 7'($urandom),
                               f5, 3'($urandom), pick_opcode());
            end
            instr_q.push_back(w);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every request taken and every result back, then a short tail
        while (instr_q.size() != 0 || i_in_valid || decode_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        if (err_cnt == 0 && decode_q.size() == 0) begin
            $display("riscv_main_and_alu_decoder_core_tb: done, clean");
        end else begin
            $display("riscv_main_and_alu_decoder_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rvdec_pkg.sv
rtl/rvdec_ctrl_dec.sv
rtl/rvdec_alu_dec.sv
rtl/riscv_main_and_alu_decoder_core.sv
tb/riscv_main_and_alu_decoder_core_tb.sv
